/* sv/fpcc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_pkg
// Shared constants, codes and controller/datapath signal groups of the
// fragment pair coverage counter.
// ----------------------------------------------------------------------------
package fpcc_pkg;

    localparam int HIT_DEPTH  = 65536;
    localparam int POS_BITS   = 28;

    localparam int ADDR_W     = $clog2(HIT_DEPTH);
    localparam int CNT_W      = $clog2(HIT_DEPTH + 1);
    localparam int ENTRY_W    = POS_BITS + 1;
    localparam int SUM_W      = POS_BITS + 1;

    localparam int OPCODE_W   = 2;
    localparam int IN_POS_W   = 28;
    localparam int ANCHOR_W   = 17;
    localparam int PAIR_W     = 24;
    localparam int GAP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PAIR_W-1:0] PAIR_MAX      = {PAIR_W{1'b1}};
    localparam logic [GAP_W-1:0]  MIN_GAP_RESET = GAP_W'(0);
    localparam logic [GAP_W-1:0]  MAX_GAP_RESET = GAP_W'(400);

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_SAMPLE  = 2'd0,
        OP_LOAD_CONTROL = 2'd1,
        OP_QUERY        = 2'd2,
        OP_CLEAR        = 2'd3
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = CFG_IDX_W'(1);

    typedef struct packed {
        logic load_sample;
        logic load_control;
        logic clear;
        logic start;
        logic init;
        logic rd;
        logic rd_j;
        logic idx_dec;
        logic idx_inc;
        logic fwd;
        logic j_inc;
        logic pair;
        logic list_end;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic back_more;
        logic idx_zero;
        logic idx_lt_n;
        logic pos_lt_summit;
        logic fwd_hit;
        logic j_lt_n;
        logic in_window;
        logic list_ctl;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

/* sv/fpcc_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_in_if
// Input channel: load, query and clear words.
// ----------------------------------------------------------------------------
interface fpcc_in_if;
    logic                            valid;
    logic                            ready;
    logic [fpcc_pkg::OPCODE_W-1:0]   opcode;
    logic [fpcc_pkg::IN_POS_W-1:0]   position;
    logic                            strand;
    logic [fpcc_pkg::ANCHOR_W-1:0]   sample_anchor;
    logic [fpcc_pkg::ANCHOR_W-1:0]   control_anchor;

    modport source (output valid, opcode, position, strand, sample_anchor,
                    control_anchor, input ready);
    modport sink   (input valid, opcode, position, strand, sample_anchor,
                    control_anchor, output ready);
endinterface
`default_nettype wire

/* sv/fpcc_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_out_if
// Result channel: pair counts and keep flag of one query.
// ----------------------------------------------------------------------------
interface fpcc_out_if;
    logic                          valid;
    logic                          ready;
    logic [fpcc_pkg::PAIR_W-1:0]   sample_pairs;
    logic [fpcc_pkg::PAIR_W-1:0]   control_pairs;
    logic                          keep;

    modport source (output valid, sample_pairs, control_pairs, keep, input ready);
    modport sink   (input valid, sample_pairs, control_pairs, keep, output ready);
endinterface
`default_nettype wire

/* sv/fpcc_cfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fpcc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fpcc_pkg::CFG_IDX_W-1:0]    index;
    logic [fpcc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/fpcc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fpcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* sv/fpcc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_ctrl
// Sequencer: takes input words and steps the backward scan, the forward hit
// walk and the reverse hit walk of each list through the datapath.
// ----------------------------------------------------------------------------
module fpcc_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [fpcc_pkg::OPCODE_W-1:0]   i_opcode,
    output logic                                 o_ready,
    input  wire fpcc_pkg::t_status               i_status,
    output fpcc_pkg::t_cmd                       o_cmd
);
    import fpcc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_INIT     = 10'b00_0000_0010,
        S_BACK_RD  = 10'b00_0000_0100,
        S_BACK_EV  = 10'b00_0000_1000,
        S_OUT_RD   = 10'b00_0001_0000,
        S_OUT_EV   = 10'b00_0010_0000,
        S_IN_RD    = 10'b00_0100_0000,
        S_IN_EV    = 10'b00_1000_0000,
        S_LIST_END = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_opcode op;
    logic    accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign op      = t_opcode'(i_opcode);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_LOAD_SAMPLE:  o_cmd.load_sample  = 1'b1;
                        OP_LOAD_CONTROL: o_cmd.load_control = 1'b1;
                        OP_CLEAR:        o_cmd.clear        = 1'b1;
                        OP_QUERY: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_status.n_zero ? S_LIST_END : S_BACK_RD;
            end
            S_BACK_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_BACK_EV;
            end
            S_BACK_EV: begin
                if (i_status.back_more && !i_status.idx_zero) begin
                    o_cmd.idx_dec = 1'b1;
                    n_state       = S_BACK_RD;
                end else if (i_status.back_more) begin
                    n_state = S_OUT_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                if (i_status.idx_lt_n) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_OUT_EV;
                end else begin
                    n_state = S_LIST_END;
                end
            end
            S_OUT_EV: begin
                if (!i_status.pos_lt_summit) begin
                    n_state = S_LIST_END;
                end else if (i_status.fwd_hit) begin
                    o_cmd.fwd = 1'b1;
                    n_state   = S_IN_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_OUT_RD;
                end
            end
            S_IN_RD: begin
                if (i_status.j_lt_n) begin
                    o_cmd.rd   = 1'b1;
                    o_cmd.rd_j = 1'b1;
                    n_state    = S_IN_EV;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_OUT_RD;
                end
            end
            S_IN_EV: begin
                if (i_status.in_window) begin
                    o_cmd.pair  = 1'b1;
                    o_cmd.j_inc = 1'b1;
                    n_state     = S_IN_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_OUT_RD;
                end
            end
            S_LIST_END: begin
                o_cmd.list_end = 1'b1;
                n_state        = i_status.list_ctl ? S_DONE : S_INIT;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

/* sv/fpcc_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpcc_datapath
// Hit memories, list counts, gap registers, scan indexes, pair counter and
// result register.
// ----------------------------------------------------------------------------
module fpcc_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire fpcc_pkg::t_cmd                    i_cmd,
    output fpcc_pkg::t_status                      o_status,
    input  wire logic [fpcc_pkg::IN_POS_W-1:0]     i_position,
    input  wire logic                              i_strand,
    input  wire logic [fpcc_pkg::ANCHOR_W-1:0]     i_sample_anchor,
    input  wire logic [fpcc_pkg::ANCHOR_W-1:0]     i_control_anchor,
    input  wire logic                              i_cfg_valid,
    input  wire logic [fpcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fpcc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                   o_cfg_ready,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [fpcc_pkg::PAIR_W-1:0]       o_sample_pairs,
    output logic      [fpcc_pkg::PAIR_W-1:0]       o_control_pairs,
    output logic                                   o_keep
);
    import fpcc_pkg::*;

    logic [GAP_W-1:0]    r_min_gap;
    logic [GAP_W-1:0]    r_max_gap;
    logic [CNT_W-1:0]    r_scount;
    logic [CNT_W-1:0]    r_ccount;
    logic [POS_BITS-1:0] r_summit;
    logic [ANCHOR_W-1:0] r_sa;
    logic [ANCHOR_W-1:0] r_ca;
    logic                r_list;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_j;
    logic [POS_BITS-1:0] r_fpos;
    logic [PAIR_W-1:0]   r_cnt;
    logic [PAIR_W-1:0]   r_sres;
    logic                r_ovalid;
    logic [PAIR_W-1:0]   r_osp;
    logic [PAIR_W-1:0]   r_ocp;
    logic                r_okeep;

    logic [CNT_W-1:0]    n_cnt_list;
    logic [ANCHOR_W-1:0] anchor;
    logic                anchor_ge_n;
    logic [CNT_W-1:0]    start_idx;
    logic [ENTRY_W-1:0]  s_rdata;
    logic [ENTRY_W-1:0]  c_rdata;
    logic [ENTRY_W-1:0]  rdata;
    logic [POS_BITS-1:0] hit_pos;
    logic                hit_rev;
    logic [CNT_W-1:0]    rd_idx;
    logic [ADDR_W-1:0]   raddr;
    logic [ENTRY_W-1:0]  wdata;
    logic                s_we;
    logic                c_we;
    logic                past_summit;
    logic                pair_ok;

    // hit memories
    assign wdata = {i_strand, POS_BITS'(i_position)};
    assign s_we  = i_cmd.load_sample  && (r_scount < CNT_W'(HIT_DEPTH));
    assign c_we  = i_cmd.load_control && (r_ccount < CNT_W'(HIT_DEPTH));
    assign rd_idx = i_cmd.rd_j ? r_j : r_idx;
    assign raddr  = rd_idx[ADDR_W-1:0];

    fpcc_ram #(.WIDTH(ENTRY_W), .DEPTH(HIT_DEPTH)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_scount[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (s_rdata)
    );

    fpcc_ram #(.WIDTH(ENTRY_W), .DEPTH(HIT_DEPTH)) u_control_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_ccount[ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (c_rdata)
    );

    // current list view
    assign n_cnt_list  = r_list ? r_ccount : r_scount;
    assign anchor      = r_list ? r_ca : r_sa;
    assign anchor_ge_n = (32'(anchor) >= 32'(n_cnt_list));
    assign start_idx   = anchor_ge_n ? (n_cnt_list - CNT_W'(1)) : CNT_W'(anchor);
    assign rdata       = r_list ? c_rdata : s_rdata;
    assign hit_pos     = rdata[POS_BITS-1:0];
    assign hit_rev     = rdata[POS_BITS];

    // pair test, sample side takes hits at the summit, control only past it
    assign past_summit = r_list ? (r_summit < hit_pos) : (r_summit <= hit_pos);
    assign pair_ok     = hit_rev && past_summit &&
                         ((SUM_W'(r_fpos) + SUM_W'(r_min_gap)) < SUM_W'(hit_pos));

    always_comb begin
        o_status               = '0;
        o_status.n_zero        = (n_cnt_list == '0);
        o_status.back_more     = (SUM_W'(r_summit) < (SUM_W'(hit_pos) + SUM_W'(r_max_gap)));
        o_status.idx_zero      = (r_idx == '0);
        o_status.idx_lt_n      = (r_idx < n_cnt_list);
        o_status.pos_lt_summit = (hit_pos < r_summit);
        o_status.fwd_hit       = !hit_rev;
        o_status.j_lt_n        = (r_j < n_cnt_list);
        o_status.in_window     = (SUM_W'(hit_pos) <= (SUM_W'(r_fpos) + SUM_W'(r_max_gap)));
        o_status.list_ctl      = r_list;
        o_status.out_free      = !r_ovalid || i_ready;
    end

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= MIN_GAP_RESET;
            r_max_gap <= MAX_GAP_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_MIN_GAP) begin
                r_min_gap <= GAP_W'(i_cfg_data);
            end else if (i_cfg_index == REG_MAX_GAP) begin
                r_max_gap <= GAP_W'(i_cfg_data);
            end
        end
    end

    // list fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scount <= '0;
            r_ccount <= '0;
        end else if (i_cmd.clear) begin
            r_scount <= '0;
            r_ccount <= '0;
        end else begin
            if (s_we) begin
                r_scount <= r_scount + CNT_W'(1);
            end
            if (c_we) begin
                r_ccount <= r_ccount + CNT_W'(1);
            end
        end
    end

    // query registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list <= 1'b0;
        end else if (i_cmd.start) begin
            r_list <= 1'b0;
        end else if (i_cmd.list_end) begin
            r_list <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_summit <= POS_BITS'(i_position);
            r_sa     <= i_sample_anchor;
            r_ca     <= i_control_anchor;
        end
        if (i_cmd.init) begin
            r_idx <= start_idx;
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - CNT_W'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.fwd) begin
            r_fpos <= hit_pos;
            r_j    <= r_idx + CNT_W'(1);
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + CNT_W'(1);
        end
        if (i_cmd.init) begin
            r_cnt <= '0;
        end else if (i_cmd.pair && pair_ok && (r_cnt != PAIR_MAX)) begin
            r_cnt <= r_cnt + PAIR_W'(1);
        end
        if (i_cmd.list_end && !r_list) begin
            r_sres <= r_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_osp   <= r_sres;
            r_ocp   <= r_cnt;
            r_okeep <= (r_sres != '0);
        end
    end

    assign o_valid         = r_ovalid;
    assign o_sample_pairs  = r_osp;
    assign o_control_pairs = r_ocp;
    assign o_keep          = r_okeep;
endmodule
`default_nettype wire

/* sv/fragment_pair_coverage_count.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fragment_pair_coverage_count
// Sample and control hit lists with per-summit fragment pair counting.
// ----------------------------------------------------------------------------
// Load and clear words are handled in the idle state. A query is accepted in
// the idle state and then walks each list in turn, sample first, through the
// single read port of that list's hit memory. Each hit read is split into an
// address state and a state that evaluates the registered data. A non-empty
// list runs the backward scan and then the forward walk, which starts a pair
// walk at each forward hit. Each list then passes through a list-end state,
// and the query posts the result from a done state. An empty list goes from
// the init state straight to the list-end state. The result sits in an output
// register, so new words are taken while it waits; a query that finishes
// while the previous result still waits holds in its done state, and stalls
// the input, until that result is taken. The memories need no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module fragment_pair_coverage_count (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fpcc_in_if.sink    i_in,
    fpcc_out_if.source o_out,
    fpcc_cfg_if.sink   i_cfg
);
    import fpcc_pkg::*;

    t_cmd    cmd;
    t_status status;

    fpcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_opcode (i_in.opcode),
        .o_ready  (i_in.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    fpcc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_position       (i_in.position),
        .i_strand         (i_in.strand),
        .i_sample_anchor  (i_in.sample_anchor),
        .i_control_anchor (i_in.control_anchor),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_cfg_ready      (i_cfg.ready),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_sample_pairs   (o_out.sample_pairs),
        .o_control_pairs  (o_out.control_pairs),
        .o_keep           (o_out.keep)
    );
endmodule
`default_nettype wire

/* bench/fpcc_tb_pkg.sv */
// ----------------------------------------------------------------------------
// fpcc_tb_pkg
// Scoreboard of the fragment pair coverage counter bench: keeps its own copy
// of both hit lists and of the gap registers, predicts the pair counts of
// every accepted query word and checks the result words against them in
// order.
// ----------------------------------------------------------------------------
package fpcc_tb_pkg;
    import fpcc_pkg::*;

    typedef struct packed {
        logic [PAIR_W-1:0] sample_pairs;
        logic [PAIR_W-1:0] control_pairs;
        logic              keep;
    } t_pair_counts;

    localparam longint ABOVE_ALL = 64'sh7FFF_FFFF_FFFF_FFFF;

    class coverage_scoreboard;
        logic [ENTRY_W-1:0] sample_hits[$];
        logic [ENTRY_W-1:0] control_hits[$];
        logic [GAP_W-1:0]   min_gap;
        logic [GAP_W-1:0]   max_gap;
        t_pair_counts       pending_counts[$];
        int                 failures;

        function new();
            min_gap  = MIN_GAP_RESET;
            max_gap  = MAX_GAP_RESET;
            failures = 0;
        endfunction

        function int list_size(bit ctl);
            return ctl ? control_hits.size() : sample_hits.size();
        endfunction

        function logic [ENTRY_W-1:0] hit_entry(bit ctl, int idx);
            return ctl ? control_hits[idx] : sample_hits[idx];
        endfunction

        // entries outside the list sit above every summit
        function longint hit_position(bit ctl, int idx);
            logic [ENTRY_W-1:0] e;
            if (idx < 0 || idx >= list_size(ctl)) return ABOVE_ALL;
            e = hit_entry(ctl, idx);
            return longint'(e[POS_BITS-1:0]);
        endfunction

        function bit hit_reverse(bit ctl, int idx);
            logic [ENTRY_W-1:0] e;
            e = hit_entry(ctl, idx);
            return e[POS_BITS];
        endfunction

        // control list needs the reverse hit strictly past the summit
        function logic [PAIR_W-1:0] tally_pairs(bit ctl, longint summit, longint anchor);
            int                n;
            int                idx;
            int                j;
            longint            lo;
            longint            fwd_pos;
            longint            rev_pos;
            bit                counted;
            logic [PAIR_W-1:0] total;
            total = '0;
            n     = list_size(ctl);
            lo    = summit - longint'(max_gap);
            if (n == 0) return total;
            idx = (anchor >= n) ? n - 1 : int'(anchor);
            while (idx >= 0 && lo < hit_position(ctl, idx)) idx--;
            idx++;
            while (idx < n && hit_position(ctl, idx) < summit) begin
                if (!hit_reverse(ctl, idx)) begin
                    fwd_pos = hit_position(ctl, idx);
                    j = idx + 1;
                    while (j < n && hit_position(ctl, j) <= fwd_pos + longint'(max_gap)) begin
                        rev_pos = hit_position(ctl, j);
                        counted = hit_reverse(ctl, j) &&
                                  (fwd_pos + longint'(min_gap) < rev_pos) &&
                                  (ctl ? (summit < rev_pos) : (summit <= rev_pos));
                        if (counted && total != PAIR_MAX) total++;
                        j++;
                    end
                end
                idx++;
            end
            return total;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_MIN_GAP) begin
                min_gap = data;
            end else if (index == REG_MAX_GAP) begin
                max_gap = data;
            end
        endfunction

        function void note_word(t_opcode op, logic [IN_POS_W-1:0] position, logic strand,
                                logic [ANCHOR_W-1:0] s_anchor, logic [ANCHOR_W-1:0] c_anchor);
            logic [ENTRY_W-1:0] entry;
            t_pair_counts       counts;
            entry = {strand, position[POS_BITS-1:0]};
            case (op)
                OP_LOAD_SAMPLE: begin
                    if (sample_hits.size() < HIT_DEPTH) begin
                        sample_hits.insert(sample_hits.size(), entry);
                    end
                end
                OP_LOAD_CONTROL: begin
                    if (control_hits.size() < HIT_DEPTH) begin
                        control_hits.insert(control_hits.size(), entry);
                    end
                end
                OP_QUERY: begin
                    counts.sample_pairs  = tally_pairs(1'b0, longint'(position[POS_BITS-1:0]),
                                                       longint'(s_anchor));
                    counts.control_pairs = tally_pairs(1'b1, longint'(position[POS_BITS-1:0]),
                                                       longint'(c_anchor));
                    counts.keep          = (counts.sample_pairs != '0);
                    pending_counts.insert(pending_counts.size(), counts);
                end
                OP_CLEAR: begin
                    sample_hits.delete();
                    control_hits.delete();
                end
                default: begin
                end
            endcase
        endfunction

        function void check_counts(logic [PAIR_W-1:0] sample_pairs,
                                   logic [PAIR_W-1:0] control_pairs, logic keep);
            t_pair_counts want;
            if (pending_counts.size() == 0) begin
                $error("result word with no query outstanding: sample_pairs %0d", sample_pairs);
                failures++;
                return;
            end
            want = pending_counts.pop_front();
            if (sample_pairs !== want.sample_pairs) begin
                $error("sample_pairs: expected %0d, got %0d", want.sample_pairs, sample_pairs);
                failures++;
            end
            if (control_pairs !== want.control_pairs) begin
                $error("control_pairs: expected %0d, got %0d", want.control_pairs, control_pairs);
                failures++;
            end
            if (keep !== want.keep) begin
                $error("keep: expected %0d, got %0d", want.keep, keep);
                failures++;
            end
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction
    endclass

endpackage

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Bench of the fragment pair coverage counter: directed words for the edge
// cases, then random load/query episodes under several gap settings with
// random idling on both channels and one long result stall. Every result
// word is checked by the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    import fpcc_pkg::*;
    import fpcc_tb_pkg::*;

    localparam int unsigned POS_MAX     = (1 << POS_BITS) - 1;
    localparam int unsigned ANCHOR_MAX  = (1 << ANCHOR_W) - 1;
    localparam int          HOLD_CYCLES = 3000;
    localparam int          STALL_LIMIT = 200000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_WORDS = 200;

    logic i_clk;
    logic i_rst_n;

    fpcc_in_if  in_ch();
    fpcc_out_if res_ch();
    fpcc_cfg_if cfg_ch();

    fragment_pair_coverage_count u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    coverage_scoreboard sb;
    int                 words_sent;
    int                 stall_cycles;
    bit                 in_idle;
    bit                 out_idle;
    bit                 hold_req;
    int unsigned        lo_tab[PHASES] = '{0, 0, 65535, 20, 500, 0, 1, 0};
    int unsigned        hi_tab[PHASES] = '{400, 1, 65535, 300, 100, 65535, 2, 400};

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            sb.note_word(t_opcode'(in_ch.opcode), in_ch.position, in_ch.strand,
                         in_ch.sample_anchor, in_ch.control_anchor);
        end
        if (res_ch.valid && res_ch.ready) begin
            sb.check_counts(res_ch.sample_pairs, res_ch.control_pairs, res_ch.keep);
        end
        if (cfg_ch.valid && cfg_ch.ready) begin
            sb.set_register(cfg_ch.index, cfg_ch.data);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // result side
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = out_idle ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    function automatic int unsigned rand_anchor();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, ANCHOR_MAX) : $urandom_range(0, 64);
    endfunction

    function automatic int unsigned first_above(input int unsigned spots[$],
                                                input int unsigned summit);
        foreach (spots[i]) if (spots[i] > summit) return i;
        return spots.size();
    endfunction

    task automatic send_word(input t_opcode op, input int unsigned spot, input bit strand,
                             input int unsigned s_anchor, input int unsigned c_anchor);
        int gap;
        gap = in_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.opcode         <= op;
        in_ch.position       <= IN_POS_W'(spot);
        in_ch.strand         <= strand;
        in_ch.sample_anchor  <= ANCHOR_W'(s_anchor);
        in_ch.control_anchor <= ANCHOR_W'(c_anchor);
        in_ch.valid          <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic await_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic set_gaps(input int unsigned lo_gap, input int unsigned hi_gap);
        await_results();
        repeat (16) @(negedge i_clk);
        cfg_ch.index <= REG_MIN_GAP;
        cfg_ch.data  <= CFG_DATA_W'(lo_gap);
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.index <= REG_MAX_GAP;
        cfg_ch.data  <= CFG_DATA_W'(hi_gap);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_word(OP_QUERY, 0, 0, 0, 0);
        send_word(OP_LOAD_SAMPLE, 0, 0, ANCHOR_MAX, ANCHOR_MAX);
        send_word(OP_LOAD_SAMPLE, 100, 1, 0, 0);
        send_word(OP_LOAD_SAMPLE, POS_MAX, 1, 0, 0);
        send_word(OP_LOAD_CONTROL, 0, 0, 0, 0);
        send_word(OP_LOAD_CONTROL, 100, 1, 0, 0);
        send_word(OP_QUERY, 50, 1, 1, 1);
        send_word(OP_QUERY, 100, 0, 2, 2);
        send_word(OP_QUERY, POS_MAX, 1, ANCHOR_MAX, 1 << 16);
        send_word(OP_QUERY, 100, 0, 0, 0);
        send_word(OP_CLEAR, POS_MAX, 1, ANCHOR_MAX, ANCHOR_MAX);
        // unsorted sample list, empty control list
        send_word(OP_LOAD_SAMPLE, 300, 0, 0, 0);
        send_word(OP_LOAD_SAMPLE, 200, 0, 0, 0);
        send_word(OP_LOAD_SAMPLE, 650, 1, 0, 0);
        send_word(OP_LOAD_SAMPLE, 300, 1, 0, 0);
        send_word(OP_QUERY, 500, 0, 2, 0);
        send_word(OP_LOAD_CONTROL, POS_MAX - 10, 0, 0, 0);
        send_word(OP_LOAD_CONTROL, POS_MAX, 1, 0, 0);
        send_word(OP_QUERY, POS_MAX, 0, 4, 2);
        send_word(OP_QUERY, POS_MAX - 1, 1, 4, 1);
        send_word(OP_CLEAR, 0, 0, 0, 0);
    endtask

    task automatic run_noise();
        repeat ($urandom_range(6, 16)) begin
            send_word(t_opcode'($urandom_range(0, 3)), $urandom_range(0, POS_MAX),
                      $urandom_range(0, 1), rand_anchor(), rand_anchor());
        end
    endtask

    task automatic run_episode();
        int unsigned sample_pos[$];
        int unsigned control_pos[$];
        int unsigned base;
        int unsigned step;
        int unsigned spot;
        int unsigned summit;
        int unsigned s_anchor;
        int unsigned c_anchor;
        longint      cur;
        int          hits;
        bit          no_control;
        bit          scrambled;
        step = sb.max_gap / 3 + 1;
        if (sb.list_size(0) > 48 || sb.list_size(1) > 48 || $urandom_range(0, 9) != 0) begin
            send_word(OP_CLEAR, $urandom_range(0, POS_MAX), $urandom_range(0, 1),
                      rand_anchor(), rand_anchor());
        end
        case ($urandom_range(0, 3))
            0: base = $urandom_range(0, sb.max_gap);
            1: base = POS_MAX - $urandom_range(0, 20 * step);
            default: base = $urandom_range(0, POS_MAX);
        endcase
        hits       = $urandom_range(0, 40);
        no_control = ($urandom_range(0, 4) == 0);
        scrambled  = ($urandom_range(0, 7) == 0);
        cur        = base;
        repeat (hits) begin
            cur += $urandom_range(0, step);
            if (cur > POS_MAX) cur = POS_MAX;
            spot = int'(cur);
            if (scrambled && $urandom_range(0, 3) == 0) begin
                spot = base + $urandom_range(0, int'(cur - base));
            end
            if (!no_control && $urandom_range(0, 1) == 1) begin
                control_pos.insert(control_pos.size(), spot);
                send_word(OP_LOAD_CONTROL, spot, $urandom_range(0, 1), rand_anchor(), rand_anchor());
            end else begin
                sample_pos.insert(sample_pos.size(), spot);
                send_word(OP_LOAD_SAMPLE, spot, $urandom_range(0, 1), rand_anchor(), rand_anchor());
            end
        end
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 2))
                0: summit = $urandom_range(base, int'(cur));
                1: summit = (sample_pos.size() > 0) ?
                            sample_pos[$urandom_range(0, sample_pos.size() - 1)] : base;
                default: summit = (control_pos.size() > 0) ?
                            control_pos[$urandom_range(0, control_pos.size() - 1)] : base;
            endcase
            s_anchor = ($urandom_range(0, 6) == 0) ? rand_anchor() : first_above(sample_pos, summit);
            c_anchor = ($urandom_range(0, 6) == 0) ? rand_anchor() : first_above(control_pos, summit);
            if ($urandom_range(0, 15) == 0) await_results();
            send_word(OP_QUERY, summit, $urandom_range(0, 1), s_anchor, c_anchor);
        end
    endtask

    initial begin
        int target;
        sb                   = new();
        in_ch.valid          = 1'b0;
        in_ch.opcode         = '0;
        in_ch.position       = '0;
        in_ch.strand         = 1'b0;
        in_ch.sample_anchor  = '0;
        in_ch.control_anchor = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        in_idle              = 1'b1;
        out_idle             = 1'b1;
        hold_req             = 1'b0;
        words_sent           = 0;
        stall_cycles         = 0;
        i_rst_n              = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        lo_tab[PHASES-1] = $urandom_range(0, 65535);
        hi_tab[PHASES-1] = $urandom_range(1, 65535);
        for (int ph = 0; ph < PHASES; ph++) begin
            set_gaps(lo_tab[ph], hi_tab[ph]);
            in_idle  = (ph % 4 != 1);
            out_idle = (ph % 4 != 2);
            if (ph == 3) begin
                // result side stalls long while words keep coming
                in_idle  = 1'b0;
                hold_req = 1'b1;
            end
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                if ($urandom_range(0, 5) == 0) begin
                    run_noise();
                end else begin
                    run_episode();
                end
            end
        end

        await_results();
        repeat (64) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
